// ===== src/address_set_table_core_macros.svh =====
// Assertion helpers for the address set table.
`ifndef ADDRESS_SET_TABLE_CORE_MACROS_SVH
`define ADDRESS_SET_TABLE_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define AST_CHK(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define AST_CHK_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/ast_pkg.sv =====
package ast_pkg;

   // Default capacity of the set
   localparam int SET_DEPTH_DEF = 16;

   // Field widths of the beats
   localparam int ADDR_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_INVALID   = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_DUPLICATE = 3'd3,
      STAT_NOTFOUND  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_MOVE,
      ST_DONE
   } state_type;

   // Finished result handed from the sequencer to the output register
   typedef struct packed {
      logic               valid;
      status_type         status;
      logic               found;
      logic [COUNT_W-1:0] count;
   } res_type;

endpackage

// ===== src/ast_store.sv =====
module ast_store #(
   parameter int SET_DEPTH = ast_pkg::SET_DEPTH_DEF,
   localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_idx,
   output logic [ast_pkg::ADDR_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [ast_pkg::ADDR_W-1:0]  wr_data
);

   logic [ast_pkg::ADDR_W-1:0] mem [SET_DEPTH];
   logic [ast_pkg::ADDR_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Registered read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ast_ctrl.sv =====
module ast_ctrl #(
   parameter int SET_DEPTH = ast_pkg::SET_DEPTH_DEF,
   localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ast_pkg::func_type           req_func,
   input  logic [ast_pkg::ADDR_W-1:0]  req_ip_address,
   input  logic                        res_take,
   output ast_pkg::res_type            res,
   output logic                        rd_en,
   output logic [IDX_W-1:0]            rd_idx,
   input  logic [ast_pkg::ADDR_W-1:0]  rd_data,
   output logic                        wr_en,
   output logic [IDX_W-1:0]            wr_idx,
   output logic [ast_pkg::ADDR_W-1:0]  wr_data
);

   localparam int CNT_W = $clog2(SET_DEPTH + 1);

   ast_pkg::state_type          state_ff, state_in;
   ast_pkg::func_type           func_ff, func_in;
   logic [ast_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            issue_ff, issue_in;
   logic                        pend_ff, pend_in;
   logic [IDX_W-1:0]            pend_idx_ff, pend_idx_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            slot_ff, slot_in;
   ast_pkg::status_type         status_ff, status_in;
   logic                        found_ff, found_in;

   logic                        accept;
   logic [CNT_W-1:0]            last;
   logic [31:0]                 count_wide;

   assign accept     = req_valid && !req_stall;
   assign last       = count_ff - CNT_W'(1);
   assign count_wide = 32'(count_ff);

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ast_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Working registers of the item in flight
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      addr_ff     <= addr_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
   end

   // Sequence scan, update and result
   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      addr_in     = addr_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      hit_in      = hit_ff;
      slot_in     = slot_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      req_stall   = 1'b1;
      rd_en       = 1'b0;
      rd_idx      = issue_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_idx      = count_ff[IDX_W-1:0];
      wr_data     = addr_ff;
      res.valid   = 1'b0;
      res.status  = status_ff;
      res.found   = found_ff;
      res.count   = count_wide[ast_pkg::COUNT_W-1:0];

      case (state_ff)
         ast_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               func_in   = req_func;
               addr_in   = req_ip_address;
               issue_in  = '0;
               pend_in   = 1'b0;
               hit_in    = 1'b0;
               found_in  = 1'b0;
               status_in = ast_pkg::STAT_OK;
               if (req_func == ast_pkg::FUNC_ADD && req_ip_address == '0) begin
                  status_in = ast_pkg::STAT_INVALID;
                  state_in  = ast_pkg::ST_DONE;
               end else if (req_func == ast_pkg::FUNC_ADD &&
                            count_ff >= CNT_W'(SET_DEPTH)) begin
                  status_in = ast_pkg::STAT_FULL;
                  state_in  = ast_pkg::ST_DONE;
               end else if (req_func == ast_pkg::FUNC_NOP) begin
                  state_in = ast_pkg::ST_DONE;
               end else begin
                  state_in = ast_pkg::ST_SCAN;
               end
            end
         end

         ast_pkg::ST_SCAN: begin
            // Compare the entry read last cycle, issue the next read
            if (pend_ff && rd_data == addr_ff) begin
               hit_in   = 1'b1;
               slot_in  = pend_idx_ff;
               pend_in  = 1'b0;
               state_in = ast_pkg::ST_ACT;
            end else if (!pend_ff && issue_ff >= count_ff) begin
               hit_in   = 1'b0;
               state_in = ast_pkg::ST_ACT;
            end else if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
         end

         ast_pkg::ST_ACT: begin
            state_in = ast_pkg::ST_DONE;
            case (func_ff)
               ast_pkg::FUNC_ADD: begin
                  if (hit_ff) begin
                     status_in = ast_pkg::STAT_DUPLICATE;
                  end else begin
                     // Append at the end of the held entries
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               ast_pkg::FUNC_REMOVE: begin
                  if (hit_ff) begin
                     // Fetch the last entry to fill the freed slot
                     rd_en    = 1'b1;
                     rd_idx   = last[IDX_W-1:0];
                     state_in = ast_pkg::ST_MOVE;
                  end else begin
                     status_in = ast_pkg::STAT_NOTFOUND;
                  end
               end
               ast_pkg::FUNC_LOOKUP: begin
                  found_in = hit_ff;
               end
               default: begin
                  status_in = ast_pkg::STAT_OK;
               end
            endcase
         end

         ast_pkg::ST_MOVE: begin
            // Move the last entry into the freed slot and shrink
            wr_en    = 1'b1;
            wr_idx   = slot_ff;
            wr_data  = rd_data;
            count_in = last;
            state_in = ast_pkg::ST_DONE;
         end

         ast_pkg::ST_DONE: begin
            if (res_take) begin
               res.valid = 1'b1;
               state_in  = ast_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ast_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/address_set_table_core.sv =====
// Channel   Beat          Handshake            Payload
// req       one request   req_valid/req_stall  req_func, req_ip_address
// rsp       one result    rsp_valid/rsp_stall  rsp_status, rsp_found, rsp_entry_count
//
// One request at a time: accept, scan of the held entries at one read per cycle
// through the single registered read port, an update step, a move step for a
// remove that moves the last entry, then the result. A zero add, a full add or
// the unused selector skips the scan and the update and goes straight to the result.
// Sync reset empties the set.
// A stalled result waits in the output register while the next request runs.
`include "address_set_table_core_macros.svh"

module address_set_table_core #(
   parameter int SET_DEPTH = ast_pkg::SET_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ast_pkg::FUNC_W-1:0]    req_func,
   input  logic [ast_pkg::ADDR_W-1:0]    req_ip_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ast_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_found,
   output logic [ast_pkg::COUNT_W-1:0]   rsp_entry_count
);

   localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

   ast_pkg::res_type             res;
   logic                         res_take;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_idx;
   logic [ast_pkg::ADDR_W-1:0]   rd_data;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_idx;
   logic [ast_pkg::ADDR_W-1:0]   wr_data;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ast_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [ast_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   ast_ctrl #(
      .SET_DEPTH (SET_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (ast_pkg::func_type'(req_func)),
      .req_ip_address (req_ip_address),
      .res_take       (res_take),
      .res            (res),
      .rd_en          (rd_en),
      .rd_idx         (rd_idx),
      .rd_data        (rd_data),
      .wr_en          (wr_en),
      .wr_idx         (wr_idx),
      .wr_data        (wr_data)
   );

   ast_store #(
      .SET_DEPTH (SET_DEPTH)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   // Load the output register when empty or drained this cycle
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (res.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res.status;
         rsp_found_in  = res.found;
         rsp_count_in  = res.count;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   `AST_CHK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "idle after accept")
   `AST_CHK(a_result_only_in_flight, !res.valid || req_stall, "result while idle")
   `AST_CHK(a_found_ok, !(rsp_valid && rsp_found) || rsp_status == ast_pkg::STAT_OK, "found not ok")

endmodule

// ===== test/address_set_watch.sv =====
module address_set_watch
   import ast_pkg::*;
#(
   parameter int DEPTH = SET_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ADDR_W-1:0]   req_ip_address,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic                rsp_found,
   input  logic [COUNT_W-1:0]  rsp_entry_count,
   output int                  error_count,
   output int                  pending
);

   typedef struct packed {
      status_type         status;
      logic               found;
      logic [COUNT_W-1:0] count;
   } set_reply_t;

   // Shadow copy of the set: only slots below held_total are meaningful
   logic [ADDR_W-1:0] held_addr [DEPTH];
   int                held_total = 0;
   set_reply_t        pending_replies [$];
   set_reply_t        want;
   int                errors = 0;

   // Return the slot holding the address, or -1 when it is not held
   function automatic int find_slot(logic [ADDR_W-1:0] addr);
      for (int k = 0; k < held_total; k++) begin
         if (held_addr[k] == addr) return k;
      end
      return -1;
   endfunction

   // Apply one request to the shadow set and return the reply it causes
   function automatic set_reply_t predict_reply(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr);
      set_reply_t reply;
      int         slot;
      reply.status = STAT_OK;
      reply.found  = 1'b0;
      case (func_type'(fn))
         FUNC_ADD: begin
            // zero check wins over full, full wins over duplicate
            if (addr == '0) begin
               reply.status = STAT_INVALID;
            end else if (held_total >= DEPTH) begin
               reply.status = STAT_FULL;
            end else if (find_slot(addr) >= 0) begin
               reply.status = STAT_DUPLICATE;
            end else begin
               held_addr[held_total] = addr;
               held_total++;
            end
         end
         FUNC_REMOVE: begin
            // fill the hole with the last entry
            slot = find_slot(addr);
            if (slot >= 0) begin
               held_addr[slot] = held_addr[held_total-1];
               held_total--;
            end else begin
               reply.status = STAT_NOTFOUND;
            end
         end
         FUNC_LOOKUP: reply.found = (find_slot(addr) >= 0);
         default: ;
      endcase
      reply.count = held_total[COUNT_W-1:0];
      return reply;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_total = 0;
         pending_replies.delete();
      end else begin
         // Match a result beat against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               $error("result beat with nothing expected: status %0d, found %0d, count %0d",
                      rsp_status, rsp_found, rsp_entry_count);
               errors++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  errors++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
                  errors++;
               end
            end
         end
         // Predict the reply of an accepted request beat
         if (req_valid && !req_stall) begin
            pending_replies.push_back(predict_reply(req_func, req_ip_address));
         end
      end
      pending     <= pending_replies.size();
      error_count <= errors;
   end

endmodule

// ===== test/tb.sv =====
module tb;
   import ast_pkg::*;

   localparam int POOL_SIZE     = 24;
   localparam int RANDOM_ITEMS  = 620;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 250;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func;
   logic [ADDR_W-1:0]   req_ip_address;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_found;
   logic [COUNT_W-1:0]  rsp_entry_count;
   int                  mismatch_total;
   int                  awaiting;
   int                  cycle_count = 0;
   logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   address_set_table_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_ip_address  (req_ip_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_entry_count (rsp_entry_count)
   );

   address_set_watch watch (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_ip_address  (req_ip_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_entry_count (rsp_entry_count),
      .error_count     (mismatch_total),
      .pending         (awaiting)
   );

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one request beat and hold it until accepted
   task automatic send_beat(input func_type fn, input logic [ADDR_W-1:0] addr);
      req_valid      <= 1'b1;
      req_func       <= fn;
      req_ip_address <= addr;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait for every outstanding reply
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   // Result side stall pattern, with one long hold-off
   initial begin : stall_pattern
      int unsigned seg;
      int unsigned mode;
      int unsigned period;
      int unsigned elapsed;
      bit          hold_done;
      rsp_stall = 1'b0;
      elapsed   = 0;
      hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && elapsed > 1500) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         seg    = $urandom_range(60, 8);
         mode   = $urandom_range(3);
         period = $urandom_range(6, 2);
         repeat (seg) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(9) < 3);
               2: rsp_stall <= ($urandom_range(9) < 7);
               default: rsp_stall <= ((elapsed % period) < (period / 2));
            endcase
            @(posedge clock);
            elapsed++;
         end
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      int unsigned       sent;
      int unsigned       burst;
      int unsigned       gap;
      int unsigned       roll;
      int unsigned       add_pct;
      int unsigned       rem_pct;
      logic [ADDR_W-1:0] addr;
      func_type          fn;
      bit                drained_mid;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_NOP;
      req_ip_address = '0;
      drained_mid    = 1'b0;

      // Distinct nonzero addresses, never 1 or all ones
      for (int k = 0; k < POOL_SIZE; k++) begin
         addr_pool[k] = ($urandom & 32'hFFFF_FFC0) | (k + 2);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty set, zero address, extremes, duplicate, full, moves
      send_beat(FUNC_NOP, '1);
      send_beat(FUNC_LOOKUP, 32'h0000_0001);
      send_beat(FUNC_REMOVE, 32'h0000_0001);
      send_beat(FUNC_ADD, '0);
      send_beat(FUNC_ADD, '1);
      send_beat(FUNC_ADD, '1);
      send_beat(FUNC_LOOKUP, '1);
      send_beat(FUNC_LOOKUP, '0);
      send_beat(FUNC_REMOVE, '0);
      send_beat(FUNC_ADD, 32'h0000_0001);
      for (int k = 0; k < 14; k++) send_beat(FUNC_ADD, addr_pool[k]);
      send_beat(FUNC_ADD, addr_pool[20]);
      send_beat(FUNC_ADD, '0);
      send_beat(FUNC_ADD, '1);
      send_beat(FUNC_REMOVE, addr_pool[5]);
      send_beat(FUNC_LOOKUP, addr_pool[13]);
      send_beat(FUNC_REMOVE, '1);
      wait_drained();

      // Random bursts, each leaning toward filling, draining or a mix
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(20, 1);
         case ($urandom_range(2))
            0: begin add_pct = 70; rem_pct = 12; end
            1: begin add_pct = 15; rem_pct = 60; end
            default: begin add_pct = 35; rem_pct = 30; end
         endcase
         repeat (burst) begin
            roll = $urandom_range(99);
            if (roll < 75) addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            else if (roll < 87) addr = $urandom;
            else if (roll < 94) addr = '0;
            else addr = '1;
            roll = $urandom_range(99);
            if (roll < add_pct) fn = FUNC_ADD;
            else if (roll < add_pct + rem_pct) fn = FUNC_REMOVE;
            else if (roll < 95) fn = FUNC_LOOKUP;
            else fn = FUNC_NOP;
            send_beat(fn, addr);
            sent++;
         end
         // Pause once midway until all replies are back
         if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
            wait_drained();
            drained_mid = 1'b1;
         end
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && awaiting == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/ast_pkg.sv
src/ast_store.sv
src/ast_ctrl.sv
src/address_set_table_core.sv
test/address_set_watch.sv
test/tb.sv
